FILE: rtl/core/kmw_pkg.sv
// shared types and constants of the kruskal maze wall remover
package kmw_pkg;

  // grid geometry
  localparam int Side    = 8;
  localparam int Cells   = Side * Side;
  localparam int AddrW   = $clog2(Cells);
  localparam int LabelW  = 6;
  localparam int MergeW  = 6;
  localparam int CoordW  = 3;

  // stream payload widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 24;

  // request kinds
  localparam logic [1:0] KindRestart = 2'd0;
  localparam logic [1:0] KindKnock   = 2'd1;

  // knock directions
  localparam logic [1:0] DirDown  = 2'd0;
  localparam logic [1:0] DirRight = 2'd1;
  localparam logic [1:0] DirUp    = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    StKnocked = 3'd0,
    StJoined  = 3'd1,
    StOffGrid = 3'd2,
    StCleared = 3'd3,
    StRead    = 3'd4
  } status_e;

  // one memory word per cell
  typedef struct packed {
    logic [LabelW-1:0] label;
    logic              down;
    logic              right;
  } cell_t;

  localparam int CellW = $bits(cell_t);

endpackage

FILE: rtl/core/kmw_ram.sv
// generic single write, single read ram with registered read data
module kmw_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/kruskal_maze_wall_remover.sv
// kruskal maze wall remover: cell labels and passages in one ram, relabel sweep
//
//  channel   | dir | payload
//  s_axis    | in  | tdata: kind[1:0] row[4:2] col[7:5] direction[9:8]
//  m_axis    | out | tdata: status, remaining, finished, open_down, open_right, cell_set
//
// restart and off-grid knocks go straight to the done state, a read passes
// here, a knock here and there; opening a wall adds the relabel sweep
// over all 64 cell words through the single ram read port, one word a cycle.
// reset and restart reload every cell at once through per-cell valid bits.
// a finished result waits in the output register; the next request is taken
// while it waits, and a stalled output holds the block in its final state.
module kruskal_maze_wall_remover (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // kind, row, col, direction from the lowest bit up
  input  logic [kmw_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status, remaining, finished, open_down, open_right, cell_set from the lowest bit up
  output logic [kmw_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import kmw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HERE  = 3'd1;
  localparam logic [2:0] S_THERE = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [AddrW-1:0]  LastAddr   = AddrW'(Cells - 1);
  localparam logic [MergeW-1:0] MergeReset = MergeW'(Cells - 1);

  logic [2:0]        state_q, state_d;
  logic [1:0]        kind_q, kind_d;
  logic [AddrW-1:0]  there_q, there_d, wall_q, wall_d;
  logic              wall_down_q, wall_down_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;
  logic [LabelW-1:0] new_lab_q, new_lab_d, old_lab_q, old_lab_d;
  logic [MergeW-1:0] merges_q, merges_d;
  logic [Cells-1:0]  valid_q;
  logic              valid_clr;

  status_e           res_status_q, res_status_d;
  logic              res_down_q, res_down_d, res_right_q, res_right_d;
  logic [LabelW-1:0] res_set_q, res_set_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_raddr;
  cell_t            ram_wdata;
  logic [CellW-1:0] ram_rdata;
  logic [AddrW-1:0] rd_addr_q;
  logic             rd_valid_q;
  cell_t            rd_word;

  // input fields
  logic [1:0]        in_kind, in_dir;
  logic [CoordW-1:0] in_row, in_col;
  logic [CoordW:0]   row_ext, col_ext;
  logic              in_acc, restart_acc, cell_off, nb_off;
  logic [CoordW:0]   nb_row, nb_col;

  assign in_kind = s_axis_tdata_i[1:0];
  assign in_row  = s_axis_tdata_i[4:2];
  assign in_col  = s_axis_tdata_i[7:5];
  assign in_dir  = s_axis_tdata_i[9:8];
  assign row_ext = {1'b0, in_row};
  assign col_ext = {1'b0, in_col};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign restart_acc     = in_acc && (in_kind == KindRestart);

  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW:0] r,
                                                 input logic [CoordW:0] c);
    cell_addr = AddrW'(r) * AddrW'(Side) + AddrW'(c);
  endfunction

  // neighbour position and grid checks
  always_comb begin
    nb_row = row_ext;
    nb_col = col_ext;
    nb_off = 1'b0;
    cell_off = (row_ext >= (CoordW+1)'(Side)) || (col_ext >= (CoordW+1)'(Side));
    case (in_dir)
      DirDown: begin
        nb_row = row_ext + 1'b1;
        nb_off = (nb_row >= (CoordW+1)'(Side));
      end
      DirRight: begin
        nb_col = col_ext + 1'b1;
        nb_off = (nb_col >= (CoordW+1)'(Side));
      end
      DirUp: begin
        nb_row = row_ext - 1'b1;
        nb_off = (in_row == '0);
      end
      default: begin
        nb_col = col_ext - 1'b1;
        nb_off = (in_col == '0);
      end
    endcase
  end

  // cells never written since the last clear read as their reset value
  always_comb begin
    if (rd_valid_q) begin
      rd_word = cell_t'(ram_rdata);
    end else begin
      rd_word.label = LabelW'(rd_addr_q);
      rd_word.down  = 1'b0;
      rd_word.right = 1'b0;
    end
  end

  // control sequence
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    there_d      = there_q;
    wall_d       = wall_q;
    wall_down_d  = wall_down_q;
    cnt_d        = cnt_q;
    new_lab_d    = new_lab_q;
    old_lab_d    = old_lab_q;
    merges_d     = merges_q;
    res_status_d = res_status_q;
    res_down_d   = res_down_q;
    res_right_d  = res_right_q;
    res_set_d    = res_set_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    valid_clr    = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = cnt_q + 1'b1;
    ram_wdata    = rd_word;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        ram_raddr = cell_addr(row_ext, col_ext);
        if (in_acc) begin
          kind_d      = in_kind;
          there_d     = cell_addr(nb_row, nb_col);
          wall_down_d = (in_dir == DirDown) || (in_dir == DirUp);
          wall_d      = ((in_dir == DirDown) || (in_dir == DirRight)) ?
                        cell_addr(row_ext, col_ext) : cell_addr(nb_row, nb_col);
          res_down_d  = 1'b0;
          res_right_d = 1'b0;
          res_set_d   = '0;
          case (in_kind)
            KindRestart: begin
              valid_clr    = 1'b1;
              merges_d     = MergeReset;
              res_status_d = StCleared;
              state_d      = S_DONE;
            end
            KindKnock: begin
              if (cell_off || nb_off) begin
                res_status_d = StOffGrid;
                state_d      = S_DONE;
              end else begin
                state_d = S_HERE;
              end
            end
            default: begin
              if (cell_off) begin
                res_status_d = StOffGrid;
                state_d      = S_DONE;
              end else begin
                state_d = S_HERE;
              end
            end
          endcase
        end
      end
      S_HERE: begin
        ram_raddr = there_q;
        if (kind_q == KindKnock) begin
          new_lab_d = rd_word.label;
          state_d   = S_THERE;
        end else begin
          res_status_d = StRead;
          res_down_d   = rd_word.down;
          res_right_d  = rd_word.right;
          res_set_d    = rd_word.label;
          state_d      = S_DONE;
        end
      end
      S_THERE: begin
        ram_raddr = '0;
        cnt_d     = '0;
        old_lab_d = rd_word.label;
        if (rd_word.label == new_lab_q) begin
          res_status_d = StJoined;
          state_d      = S_DONE;
        end else begin
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // rewrite the word read last cycle while the next one is fetched
        ram_we = 1'b1;
        if (rd_word.label == old_lab_q) begin
          ram_wdata.label = new_lab_q;
        end
        if (rd_addr_q == wall_q) begin
          if (wall_down_q) begin
            ram_wdata.down = 1'b1;
          end else begin
            ram_wdata.right = 1'b1;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          if (merges_q != '0) begin
            merges_d = merges_q - 1'b1;
          end
          res_status_d = StKnocked;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {(OutDataW-18)'(0), res_set_q, res_right_q, res_down_q,
                         (merges_q == '0), merges_q, res_status_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // cell memory
  kmw_ram #(
    .Width(CellW),
    .Depth(Cells)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // read address and valid bit follow the ram latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_addr_q  <= ram_raddr;
      rd_valid_q <= valid_q[ram_raddr] && !valid_clr;
    end
  end

  // per-cell valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (valid_clr) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[rd_addr_q] <= 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      merges_q    <= MergeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      merges_q    <= merges_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    there_q      <= there_d;
    wall_q       <= wall_d;
    wall_down_q  <= wall_down_d;
    cnt_q        <= cnt_d;
    new_lab_q    <= new_lab_d;
    old_lab_q    <= old_lab_d;
    res_status_q <= res_status_d;
    res_down_q   <= res_down_d;
    res_right_q  <= res_right_d;
    res_set_q    <= res_set_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // merge count only drops, except on a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(restart_acc) |-> (merges_q <= $past(merges_q)))
    else $error("merge count rose without a restart");

  // the memory is only written by the relabel sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SWEEP))
    else $error("cell memory written outside the sweep");

  // finished flag agrees with the remaining count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[9] == (m_axis_tdata_o[8:3] == '0)))
    else $error("finished flag disagrees with remaining count");

endmodule

FILE: tb/tb_kruskal_maze_wall_remover.sv
// self-checking stream testbench for the kruskal maze wall remover
module tb_kruskal_maze_wall_remover;

  import kmw_pkg::*;

  // kind and direction codes that the package leaves out
  localparam logic [1:0] KindRead  = 2'd2;
  localparam logic [1:0] KindSpare = 2'd3;
  localparam logic [1:0] DirLeft   = 2'd3;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = 80;
  localparam int RandItems  = 400;
  localparam int HoldCycles = 400;
  localparam int EdgeCount  = 2 * Side * (Side - 1);

  // one request, kind in the lowest bits
  typedef struct packed {
    logic [1:0]        direction;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [1:0]        kind;
  } maze_req_t;

  // one result, status in the lowest bits
  typedef struct packed {
    logic [LabelW-1:0] cell_set;
    logic              open_right;
    logic              open_down;
    logic              finished;
    logic [MergeW-1:0] remaining;
    status_e           status;
  } maze_result_t;

  // request waiting to be offered, with its idle lead-in
  typedef struct packed {
    maze_req_t  req;
    logic [7:0] idle;
    logic       drain;
  } pending_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic [InDataW-1:0]  in_data = '0;
  logic                out_ready = 1'b0;
  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  kruskal_maze_wall_remover dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (in_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // shadow copy of the maze
  logic [LabelW-1:0] shadow_label [Cells];
  logic              shadow_down  [Cells];
  logic              shadow_right [Cells];
  logic [MergeW-1:0] shadow_merges;

  pending_t     pending_q [$];
  maze_result_t maze_result_q [$];
  int           errors = 0;
  int           rx_count = 0;
  int           hold_left = 0;
  int           holds_taken = 0;
  int           cycle_cnt = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // return every cell to its own set with all walls closed
  function automatic void clear_shadow();
    for (int i = 0; i < Cells; i++) begin
      shadow_label[i] = LabelW'(i);
      shadow_down[i]  = 1'b0;
      shadow_right[i] = 1'b0;
    end
    shadow_merges = MergeW'(Cells - 1);
  endfunction

  // apply one request to the shadow maze and return its result
  function automatic maze_result_t step_maze(maze_req_t req);
    maze_result_t      res;
    int                here;
    int                there;
    int                nr;
    int                nc;
    logic              off;
    logic [LabelW-1:0] old_lab;
    logic [LabelW-1:0] new_lab;
    res  = '0;
    nr   = req.row;
    nc   = req.col;
    off  = 1'b0;
    here = req.row * Side + req.col;
    case (req.kind)
      KindRestart: begin
        clear_shadow();
        res.status = StCleared;
      end
      KindKnock: begin
        case (req.direction)
          DirDown:  if (req.row == Side - 1) off = 1'b1; else nr = req.row + 1;
          DirRight: if (req.col == Side - 1) off = 1'b1; else nc = req.col + 1;
          DirUp:    if (req.row == 0) off = 1'b1; else nr = req.row - 1;
          default:  if (req.col == 0) off = 1'b1; else nc = req.col - 1;
        endcase
        there = nr * Side + nc;
        if (off) begin
          res.status = StOffGrid;
        end else if (shadow_label[here] == shadow_label[there]) begin
          res.status = StJoined;
        end else begin
          // the wall sits at the upper or left cell of the pair
          if (nr != req.row) shadow_down[(nr > req.row) ? here : there] = 1'b1;
          else shadow_right[(nc > req.col) ? here : there] = 1'b1;
          old_lab = shadow_label[there];
          new_lab = shadow_label[here];
          for (int i = 0; i < Cells; i++) begin
            if (shadow_label[i] == old_lab) shadow_label[i] = new_lab;
          end
          if (shadow_merges != 0) shadow_merges = shadow_merges - 1'b1;
          res.status = StKnocked;
        end
      end
      default: begin
        // the spare kind code reads as well
        res.open_down  = shadow_down[here];
        res.open_right = shadow_right[here];
        res.cell_set   = shadow_label[here];
        res.status     = StRead;
      end
    endcase
    res.remaining = shadow_merges;
    res.finished  = (shadow_merges == 0);
    return res;
  endfunction

  // idle length, mostly short and now and then long
  function automatic logic [7:0] pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'd0;
    else if (r < 90) return 8'($urandom_range(1, 3));
    else if (r < 98) return 8'($urandom_range(4, 15));
    else return 8'($urandom_range(20, 60));
  endfunction

  function automatic void queue_request(logic [1:0] kind, int row, int col,
                                        logic [1:0] dir, logic drain, logic quiet);
    pending_t item;
    item.req.kind      = kind;
    item.req.row       = CoordW'(row);
    item.req.col       = CoordW'(col);
    item.req.direction = dir;
    item.idle          = quiet ? 8'd0 : pick_gap();
    item.drain         = drain;
    pending_q.push_back(item);
  endfunction

  function automatic void flag_error(string msg);
    if (errors < 10) $display("mismatch: %s", msg);
    errors++;
  endfunction

  // request driver
  maze_req_t cur_req;
  pending_t  next_item;
  int        gap_left = 0;
  logic      idle_done = 1'b0;
  logic      busy;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      clear_shadow();
    end else begin
      busy = in_valid;
      if (in_valid && s_axis_tready_o) begin
        maze_result_q.push_back(step_maze(cur_req));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain && maze_result_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!idle_done && pending_q[0].idle != 0) begin
          gap_left  = pending_q[0].idle - 1;
          idle_done = 1'b1;
          in_valid <= 1'b0;
        end else begin
          next_item = pending_q.pop_front();
          cur_req   = next_item.req;
          idle_done = 1'b0;
          in_data  <= {{(InDataW - $bits(maze_req_t)){1'b0}}, cur_req};
          in_valid <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-offs, counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_taken < 2 && rx_count >= (holds_taken == 0 ? 40 : 260)) begin
      hold_left   <= HoldCycles;
      holds_taken <= holds_taken + 1;
    end
  end

  // result monitor and receiver stalls
  maze_result_t got;
  maze_result_t want;
  int           stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && out_ready) begin
        got = maze_result_t'(m_axis_tdata_o[$bits(maze_result_t)-1:0]);
        rx_count <= rx_count + 1;
        if (maze_result_q.size() == 0) begin
          flag_error($sformatf("result %h with none expected", got));
        end else begin
          want = maze_result_q.pop_front();
          if (got.status !== want.status || got.remaining !== want.remaining ||
              got.finished !== want.finished || got.open_down !== want.open_down ||
              got.open_right !== want.open_right || got.cell_set !== want.cell_set)
            flag_error({
              $sformatf("exp st=%0d rem=%0d fin=%0d dn=%0d rt=%0d set=%0d",
                        want.status, want.remaining, want.finished, want.open_down,
                        want.open_right, want.cell_set),
              $sformatf(", got st=%0d rem=%0d fin=%0d dn=%0d rt=%0d set=%0d",
                        got.status, got.remaining, got.finished, got.open_down,
                        got.open_right, got.cell_set)});
        end
      end
      // every fourth stretch of fifty results runs without random stalls; hold-offs still apply
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if ((rx_count / 50) % 4 == 1) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus and end of run
  maze_req_t edge_list [EdgeCount];
  maze_req_t tmp_edge;
  initial begin
    int   n_edges;
    int   n_rand;
    int   episode;
    int   use_edges;
    int   j;
    int   r;
    logic quiet;

    // directed: edges of the grid, joins, reads, spare kind, restart
    queue_request(KindRestart, 0, 0, DirDown, 1'b0, 1'b0);
    queue_request(KindRead, 0, 0, DirDown, 1'b0, 1'b0);
    queue_request(KindSpare, 7, 7, DirLeft, 1'b0, 1'b0);
    queue_request(KindKnock, 7, 3, DirDown, 1'b0, 1'b0);
    queue_request(KindKnock, 2, 7, DirRight, 1'b0, 1'b0);
    queue_request(KindKnock, 0, 5, DirUp, 1'b0, 1'b0);
    queue_request(KindKnock, 4, 0, DirLeft, 1'b0, 1'b0);
    queue_request(KindKnock, 0, 0, DirRight, 1'b0, 1'b0);
    queue_request(KindKnock, 0, 1, DirLeft, 1'b0, 1'b0);
    queue_request(KindKnock, 0, 0, DirDown, 1'b0, 1'b0);
    queue_request(KindKnock, 1, 0, DirUp, 1'b0, 1'b0);
    queue_request(KindKnock, 7, 7, DirLeft, 1'b0, 1'b0);
    queue_request(KindKnock, 7, 7, DirUp, 1'b0, 1'b0);
    queue_request(KindRead, 0, 0, DirRight, 1'b0, 1'b0);
    queue_request(KindRead, 7, 6, DirUp, 1'b0, 1'b0);
    queue_request(KindRead, 6, 7, DirDown, 1'b0, 1'b0);
    queue_request(KindKnock, 1, 0, DirRight, 1'b0, 1'b0);
    queue_request(KindSpare, 1, 1, DirUp, 1'b0, 1'b0);
    queue_request(KindRestart, 3, 5, DirRight, 1'b1, 1'b0);
    queue_request(KindRead, 0, 0, DirDown, 1'b0, 1'b0);

    // every wall of the grid once
    n_edges = 0;
    for (int rr = 0; rr < Side; rr++) begin
      for (int cc = 0; cc < Side; cc++) begin
        if (rr < Side - 1) begin
          edge_list[n_edges] = '{direction: DirDown, col: CoordW'(cc),
                                 row: CoordW'(rr), kind: KindKnock};
          n_edges++;
        end
        if (cc < Side - 1) begin
          edge_list[n_edges] = '{direction: DirRight, col: CoordW'(cc),
                                 row: CoordW'(rr), kind: KindKnock};
          n_edges++;
        end
      end
    end

    // random episodes: a restart, then walls in random order with reads and noise
    n_rand  = 0;
    episode = 0;
    while (n_rand < RandItems) begin
      quiet = (episode % 3 == 2);
      queue_request(KindRestart, $urandom_range(0, 7), $urandom_range(0, 7),
                    2'($urandom_range(0, 3)), episode == 1, quiet);
      n_rand++;
      for (int i = n_edges - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp_edge = edge_list[i];
        edge_list[i] = edge_list[j];
        edge_list[j] = tmp_edge;
      end
      // the first two episodes try every wall, so the maze gets finished unless a random restart comes between
      use_edges = (episode < 2) ? n_edges : $urandom_range(10, 60);
      for (int i = 0; i < use_edges; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          queue_request($urandom_range(0, 1) ? KindRead : KindSpare,
                        $urandom_range(0, 7), $urandom_range(0, 7),
                        2'($urandom_range(0, 3)), 1'b0, quiet);
          n_rand++;
        end else if (r < 18) begin
          queue_request(KindKnock, $urandom_range(0, 7), $urandom_range(0, 7),
                        2'($urandom_range(0, 3)), 1'b0, quiet);
          n_rand++;
        end else if (r < 20) begin
          queue_request(KindRestart, 0, 0, DirDown, 1'b0, quiet);
          n_rand++;
        end
        // knock the wall from one of its two sides
        tmp_edge = edge_list[i];
        if ($urandom_range(0, 1)) begin
          queue_request(KindKnock, tmp_edge.row, tmp_edge.col,
                        tmp_edge.direction, 1'b0, quiet);
        end else if (tmp_edge.direction == DirDown) begin
          queue_request(KindKnock, tmp_edge.row + 1, tmp_edge.col, DirUp, 1'b0, quiet);
        end else begin
          queue_request(KindKnock, tmp_edge.row, tmp_edge.col + 1, DirLeft, 1'b0, quiet);
        end
        n_rand++;
      end
      // knocks and reads on the finished or partial maze
      for (int i = 0; i < 4; i++) begin
        queue_request(2'($urandom_range(1, 3)), $urandom_range(0, 7),
                      $urandom_range(0, 7), 2'($urandom_range(0, 3)), 1'b0, quiet);
        n_rand++;
      end
      episode++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid || maze_result_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (maze_result_q.size() != 0) flag_error("results still outstanding");

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
